FILE: hdl/tli_pkg.sv
package tli_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = 6;
  localparam int CntW      = 7;
  localparam int ValW      = 32;
  localparam int QDepth    = 2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFew      = 3'd1;
  localparam logic [2:0] StBelow    = 3'd2;
  localparam logic [2:0] StAbove    = 3'd3;
  localparam logic [2:0] StZeroSpan = 3'd4;

  localparam logic CfgCount = 1'b0;
  localparam logic CfgMode  = 1'b1;

  // one item handed from the front to the back
  typedef struct packed {
    logic            is_query;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] ex;
    logic [ValW-1:0] ey;
    logic [ValW-1:0] qx;
  } item_t;

  typedef struct packed {
    logic [ValW-1:0] y;
    logic [2:0]      status;
    logic [IdxW-1:0] seg;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_ENDS, S_ENDS, S_SRCH_RD, S_SRCH, S_SEG_RD, S_SEG,
    S_MUL, S_DIV, S_DONE, S_OUT
  } bst_t;

endpackage

FILE: hdl/table_linear_interpolator.sv
// Piecewise-linear (interp_mode 1) or nearest-point (interp_mode 0) lookup over up to 64 signed Q16.16 points.
// Input channel: in_push/in_full. req_type 0 writes one point (no result),
// req_type 1 queries query_x and produces one result.
// Result channel: out_empty/out_pop with result_y, status, segment_index.
// cfg_we/cfg_addr/cfg_data write point_count (0) and interp_mode (1); the user
// must write them only while the block is idle, which the block does not enforce.
// A two-entry queue separates the input from the lookup sequencer.
// A write reaches the table once the sequencer takes it from the queue, and
// writes stream at one per cycle while the sequencer is idle. A query reads
// the two end points, runs the binary search, reads the two segment points,
// multiplies and then runs the bit-serial restoring divide of the product.
// Too few points or x outside the table ends after the end-point reads.
// One item is processed at a time by the sequencer.
// Reset empties the queue and result; table contents are undefined.
// A stalled receiver holds the result and the queue fills, raising in_full.
module table_linear_interpolator import tli_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_req_type,
  input  logic [IdxW-1:0]        in_entry_index,
  input  logic signed [ValW-1:0] in_entry_x,
  input  logic signed [ValW-1:0] in_entry_y,
  input  logic signed [ValW-1:0] in_query_x,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic signed [ValW-1:0] out_result_y,
  output logic [2:0]             out_status,
  output logic [IdxW-1:0]        out_segment_index,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [CntW-1:0]        cfg_data
);

  logic [CntW-1:0] count_r;
  logic            mode_r;
  logic            q_valid, q_take, res_valid;
  item_t           q_item;
  item_t           push_item;
  res_t            res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CfgCount: count_r <= cfg_data;
        CfgMode:  mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign push_item = '{is_query: in_req_type, idx: in_entry_index, ex: in_entry_x,
                       ey: in_entry_y, qx: in_query_x};

  tli_front u_front (
    .clk, .rst_n, .in_push, .in_full,
    .in_item(push_item),
    .q_valid, .q_take, .q_item
  );

  tli_back u_back (
    .clk, .rst_n, .point_count(count_r), .interp_mode(mode_r),
    .q_valid, .q_take(q_take), .q_item,
    .res_valid, .res_take(out_pop), .res
  );

  assign out_empty         = !res_valid;
  assign out_result_y      = res.y;
  assign out_status        = res.status;
  assign out_segment_index = res.seg;

endmodule

FILE: hdl/tli_front.sv
module tli_front import tli_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_push,
  output logic  in_full,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_take,
  output item_t q_item
);

  item_t             mem_r [QDepth];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push_ok;

  assign in_full = (cnt_r == 2'(QDepth));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  // small item queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (q_take && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(q_take && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= in_item;
  end

endmodule

FILE: hdl/tli_back.sv
module tli_back import tli_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [CntW-1:0] point_count,
  input  logic            interp_mode,
  input  logic            q_valid,
  output logic            q_take,
  input  item_t           q_item,
  output logic            res_valid,
  input  logic            res_take,
  output res_t            res
);

  logic [ValW-1:0] xm [MaxPoints];
  logic [ValW-1:0] ym [MaxPoints];

  bst_t state_r, state_nxt;
  logic [IdxW-1:0] ra_r;
  logic signed [ValW-1:0] xrd_r, yrd_r;
  logic signed [ValW-1:0] qx_r, x0_r, xl_r, x1_r, x3_r, y1_r, y3_r;
  logic [CntW-1:0] n_r, lo_r, hi_r;
  logic asc_r, step_r;
  logic [IdxW-1:0] seg_r;
  logic [2:0] st_r;
  logic [ValW-1:0] yo_r;
  logic [2*ValW+1:0] prod_r;
  logic [ValW:0] dd_r;
  logic [ValW+1:0] rem_r;
  logic [2*ValW+1:0] quo_r;
  logic [6:0] bit_r;
  logic neg_r;

  logic [CntW-1:0] mid;
  logic signed [ValW:0] dx, dy, dd, d31, d13;
  logic [ValW+1:0] rem_sh;
  logic signed [ValW+1:0] sum;
  logic go_lo, srch_more, end_err;
  logic [CntW-1:0] lo_nxt, hi_nxt, mid_nxt, seg_sel;

  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign res_valid = (state_r == S_OUT);
  assign res       = '{y: yo_r, status: st_r, seg: seg_r};
  assign mid       = (lo_r + hi_r) >> 1;
  assign dx  = (ValW+1)'(qx_r) - (ValW+1)'(x1_r);
  assign dy  = (ValW+1)'(y3_r) - (ValW+1)'(y1_r);
  assign dd  = (ValW+1)'(x3_r) - (ValW+1)'(x1_r);
  assign d31 = (ValW+1)'(x3_r) - (ValW+1)'(qx_r);
  assign d13 = dx;
  assign rem_sh = {rem_r[ValW:0], prod_r[7'(bit_r)]};
  assign sum = (ValW+2)'(y1_r) + (neg_r ? -(ValW+2)'(quo_r[ValW+1:0])
                                       : (ValW+2)'(quo_r[ValW+1:0]));

  // one binary-search step and the address of the next read
  assign go_lo     = asc_r ? (qx_r >= xrd_r) : (qx_r <= xrd_r);
  assign lo_nxt    = go_lo ? mid : lo_r;
  assign hi_nxt    = go_lo ? hi_r : mid;
  assign srch_more = (hi_nxt - lo_nxt) > CntW'(1);
  assign mid_nxt   = (lo_nxt + hi_nxt) >> 1;
  // exact end points map to the end segments
  assign seg_sel   = (qx_r == x0_r) ? '0 :
                     (qx_r == xl_r) ? n_r - CntW'(2) :
                     (lo_nxt > n_r - CntW'(2)) ? n_r - CntW'(2) : lo_nxt;

  // too few points or x outside the table, known once both ends are read
  assign end_err = (n_r < CntW'(2)) ||
                   (xrd_r >= x0_r ? (qx_r > xrd_r || qx_r < x0_r)
                                  : (qx_r < xrd_r || qx_r > x0_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (q_valid && q_item.is_query) state_nxt = S_RD_ENDS;
      S_RD_ENDS: state_nxt = S_ENDS;
      S_ENDS:    state_nxt = !step_r ? S_RD_ENDS : (end_err ? S_OUT : S_SRCH_RD);
      S_SRCH_RD: state_nxt = S_SRCH;
      S_SRCH:    state_nxt = srch_more ? S_SRCH_RD : S_SEG_RD;
      S_SEG_RD:  state_nxt = S_SEG;
      S_SEG:     state_nxt = step_r ? S_MUL : S_SEG_RD;
      S_MUL:     state_nxt = S_DIV;
      S_DIV:     state_nxt = (bit_r == 7'd0) ? S_DONE : S_DIV;
      S_DONE:    state_nxt = S_OUT;
      S_OUT:     if (res_take) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // table memory, one read port
  always_ff @(posedge clk) begin
    if (q_take && !q_item.is_query) begin
      xm[q_item.idx] <= q_item.ex;
      ym[q_item.idx] <= q_item.ey;
    end
    xrd_r <= xm[ra_r];
    yrd_r <= ym[ra_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        qx_r   <= q_item.qx;
        n_r    <= (point_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : point_count;
        ra_r   <= '0;
        step_r <= 1'b0;
        seg_r  <= '0;
        yo_r   <= '0;
        st_r   <= StOk;
      end
      S_RD_ENDS: ;
      S_ENDS: begin
        if (!step_r) begin
          x0_r   <= xrd_r;
          ra_r   <= IdxW'(n_r - 1);
          step_r <= 1'b1;
        end else begin
          xl_r <= xrd_r;
          asc_r <= xrd_r >= x0_r;
          lo_r <= '0;
          hi_r <= n_r;
          ra_r <= IdxW'((n_r) >> 1);
          // range and count checks after both ends are known
          if (n_r < CntW'(2)) begin
            st_r <= StFew;
          end else if (xrd_r >= x0_r ? qx_r > xrd_r : qx_r < xrd_r) begin
            st_r <= StAbove;
          end else if (xrd_r >= x0_r ? qx_r < x0_r : qx_r > x0_r) begin
            st_r <= StBelow;
          end
        end
      end
      S_SRCH_RD: ;
      S_SRCH: begin
        lo_r   <= lo_nxt;
        hi_r   <= hi_nxt;
        step_r <= 1'b0;
        if (srch_more) begin
          ra_r <= IdxW'(mid_nxt);
        end else begin
          ra_r  <= IdxW'(seg_sel);
          seg_r <= IdxW'(seg_sel);
        end
      end
      S_SEG_RD: ;
      S_SEG: begin
        if (!step_r) begin
          x1_r <= xrd_r; y1_r <= yrd_r; step_r <= 1'b1;
          ra_r <= IdxW'(seg_r + 1);
        end else begin
          x3_r <= xrd_r; y3_r <= yrd_r;
        end
      end
      S_MUL: begin
        prod_r <= (2*ValW+2)'(dx[ValW] ? -dx : dx) * (2*ValW+2)'(dy[ValW] ? -dy : dy);
        dd_r   <= dd[ValW] ? (ValW+1)'(-dd) : (ValW+1)'(dd);
        neg_r  <= (dx[ValW] != dy[ValW]) ^ dd[ValW];
        rem_r  <= '0;
        quo_r  <= '0;
        bit_r  <= 7'(2*ValW+1);
      end
      S_DIV: begin
        if (rem_sh >= (ValW+2)'(dd_r)) begin
          rem_r <= rem_sh - (ValW+2)'(dd_r);
          quo_r <= {quo_r[2*ValW:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[2*ValW:0], 1'b0};
        end
        bit_r <= bit_r - 7'd1;
      end
      S_DONE: begin
        if (dd == '0) begin
          st_r <= StZeroSpan;
        end else if (asc_r ? qx_r < x1_r : qx_r > x1_r) begin
          st_r <= StBelow; seg_r <= '0;
        end else if (asc_r ? qx_r > x3_r : qx_r < x3_r) begin
          st_r <= StAbove; seg_r <= '0;
        end else begin
          st_r <= StOk;
          if (!interp_mode) begin
            yo_r <= ((d31[ValW] ? -d31 : d31) <= (d13[ValW] ? -d13 : d13)) ? y3_r : y1_r;
          end else if (quo_r[2*ValW+1:ValW+1] != '0) begin
            yo_r <= neg_r ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
          end else if (sum[ValW+1:ValW-1] != {3{sum[ValW+1]}}) begin
            // sum does not fit the value width: clamp by its sign
            yo_r <= sum[ValW+1] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
          end else begin
            yo_r <= sum[ValW-1:0];
          end
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

endmodule

FILE: hdl/tli_checker.sv
module tli_checker import tli_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_empty,
  input logic out_pop,
  input logic [2:0] out_status,
  input logic signed [ValW-1:0] out_result_y,
  input logic [IdxW-1:0] out_segment_index
);

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= StZeroSpan) else $error("bad status");

  a_zero_y: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != StOk) |-> out_result_y == '0)
    else $error("nonzero y on error");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_y)))
    else $error("result dropped");

  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == StFew || out_status == StBelow ||
                    out_status == StAbove)) |-> out_segment_index == '0)
    else $error("segment on error");

endmodule

bind table_linear_interpolator tli_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_status, .out_result_y,
  .out_segment_index
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tli_pkg::*;

  typedef struct {
    bit               is_query;
    bit [IdxW-1:0]    idx;
    bit signed [31:0] ex;
    bit signed [31:0] ey;
    bit signed [31:0] qx;
  } lut_req_s;

  typedef struct {
    bit signed [31:0] y;
    bit [2:0]         st;
    bit [IdxW-1:0]    seg;
  } lut_ans_s;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic                   in_req_type = 1'b0;
  logic [IdxW-1:0]        in_entry_index = '0;
  logic signed [ValW-1:0] in_entry_x = '0;
  logic signed [ValW-1:0] in_entry_y = '0;
  logic signed [ValW-1:0] in_query_x = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic signed [ValW-1:0] out_result_y;
  logic [2:0]             out_status;
  logic [IdxW-1:0]        out_segment_index;
  logic                   cfg_we = 1'b0;
  logic                   cfg_addr = 1'b0;
  logic [CntW-1:0]        cfg_data = '0;

  lut_req_s pend_reqs[$];
  lut_ans_s lut_expect[$];
  lut_req_s cur_req;

  // predictor state
  longint model_x[MaxPoints];
  longint model_y[MaxPoints];
  int     model_count;
  bit     model_mode;

  // generator-side copy of the table, for aiming queries
  longint gen_x[MaxPoints];

  int  errs = 0;
  bit  quiet = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  stall_cycles = 0;

  table_linear_interpolator u_top (.*);

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errs++;
  endtask

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // table write or lookup; lookups push the expected answer
  task automatic lut_model(input lut_req_s r);
    int n, lo, hi, mid, seg;
    longint x, x1, x3, y1, y3, dx, dy, dd, yv;
    bit asc, neg;
    bit [127:0] prod, quo;
    lut_ans_s a;
    if (!r.is_query) begin
      model_x[r.idx] = r.ex;
      model_y[r.idx] = r.ey;
      return;
    end
    x = r.qx;
    n = model_count > MaxPoints ? MaxPoints : model_count;
    seg = 0;
    yv = 0;
    a.st = StOk;
    if (n < 2) begin
      a.st = StFew;
    end else begin
      asc = model_x[n-1] >= model_x[0];
      if (asc ? x > model_x[n-1] : x < model_x[n-1]) begin
        a.st = StAbove;
      end else if (asc ? x < model_x[0] : x > model_x[0]) begin
        a.st = StBelow;
      end else begin
        lo = 0;
        hi = n;
        while (hi - lo > 1) begin
          mid = (hi + lo) >> 1;
          if (asc ? x >= model_x[mid] : x <= model_x[mid]) lo = mid;
          else hi = mid;
        end
        // exact end points map to the end segments
        if (x == model_x[0]) seg = 0;
        else if (x == model_x[n-1]) seg = n - 2;
        else seg = lo;
        if (seg > n - 2) seg = n - 2;
        x1 = model_x[seg];
        x3 = model_x[seg+1];
        y1 = model_y[seg];
        y3 = model_y[seg+1];
        if (x1 == x3) begin
          a.st = StZeroSpan;
        end else if (asc ? x < x1 : x > x1) begin
          a.st = StBelow;
        end else if (asc ? x > x3 : x < x3) begin
          a.st = StAbove;
        end else if (!model_mode) begin
          // ties go to the upper point
          yv = mag(x3 - x) <= mag(x - x1) ? y3 : y1;
        end else begin
          dx = x - x1;
          dy = y3 - y1;
          dd = x3 - x1;
          neg = (dx < 0) != (dy < 0);
          if (dd < 0) neg = !neg;
          prod = 128'(mag(dx)) * 128'(mag(dy));
          quo = prod / 128'(mag(dd));
          if (quo > 128'h10_0000_0000) begin
            yv = neg ? -64'sd2147483648 : 64'sd2147483647;
          end else begin
            yv = neg ? y1 - longint'(quo) : y1 + longint'(quo);
            if (yv > 64'sd2147483647) yv = 64'sd2147483647;
            if (yv < -64'sd2147483648) yv = -64'sd2147483648;
          end
        end
        if (a.st != StOk && a.st != StZeroSpan) seg = 0;
      end
    end
    if (a.st != StOk) yv = 0;
    a.y = yv[31:0];
    a.seg = seg[IdxW-1:0];
    lut_expect.push_back(a);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_push <= 1'b0;
      end else if (pend_reqs.size() == 0) begin
        in_push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(1, 12) - 1;
        in_push <= 1'b0;
      end else begin
        cur_req = pend_reqs[0];
        in_push <= 1'b1;
        in_req_type <= cur_req.is_query;
        in_entry_index <= cur_req.idx;
        in_entry_x <= cur_req.ex;
        in_entry_y <= cur_req.ey;
        in_query_x <= cur_req.qx;
      end
    end
  end

  // result-side stall pattern
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 12) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // monitor: input transfers feed the predictor, result transfers are checked
  always @(posedge clk) begin
    lut_ans_s want;
    bit moved;
    moved = 1'b0;
    if (rst_n && in_push && !in_full) begin
      lut_model(pend_reqs.pop_front());
      moved = 1'b1;
    end
    if (rst_n && out_pop && !out_empty) begin
      moved = 1'b1;
      if (lut_expect.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        want = lut_expect.pop_front();
        if (out_result_y !== want.y) report_mismatch("result_y", out_result_y, want.y);
        if (out_status !== want.st) report_mismatch("status", out_status, want.st);
        if (out_segment_index !== want.seg)
          report_mismatch("segment_index", out_segment_index, want.seg);
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  // watchdog
  always @(posedge clk) begin
    if (stall_cycles > 5000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic lut_req_s make_write(int idx, longint x, longint y);
    lut_req_s r;
    r.is_query = 1'b0;
    r.idx = idx[IdxW-1:0];
    r.ex = x[31:0];
    r.ey = y[31:0];
    r.qx = $urandom;
    gen_x[idx] = longint'(r.ex);
    return r;
  endfunction

  function automatic lut_req_s make_query(longint x);
    lut_req_s r;
    r.is_query = 1'b1;
    r.idx = IdxW'($urandom);
    r.ex = $urandom;
    r.ey = $urandom;
    r.qx = x[31:0];
    return r;
  endfunction

  task automatic wait_idle();
    while (pend_reqs.size() != 0 || lut_expect.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic addr, int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_data = value[CntW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == CfgCount) model_count = value & 8'h7f;
    else model_mode = value[0];
  endtask

  // table shapes: ascending, descending, scrambled, ascending with repeats
  task automatic build_table(int n, int shape);
    longint step_max, v;
    step_max = $urandom_range(0, 1) ? 64'd1000 : (64'hFFFF_FFFF / n);
    v = (shape == 1) ? 64'sd2147483647 - $urandom_range(0, 100)
                     : -64'sd2147483648 + $urandom_range(0, 100);
    for (int i = 0; i < n; i++) begin
      if (shape == 2) v = longint'($signed($urandom));
      pend_reqs.push_back(make_write(i, v, longint'($signed($urandom))));
      if (shape == 3 && $urandom_range(0, 4) == 0) continue;
      if (shape == 1) v -= $urandom_range(1, step_max);
      else if (shape != 2) v += $urandom_range(1, step_max);
    end
  endtask

  function automatic longint pick_x(int n);
    int k;
    k = $urandom_range(0, n > 1 ? n - 2 : 0);
    case ($urandom_range(0, 5))
      0: return longint'($signed($urandom));
      1: return gen_x[k];
      2: return (gen_x[k] + gen_x[k+1]) >>> 1;
      3: return gen_x[k] + longint'($signed($urandom_range(0, 200))) - 100;
      4: return $urandom_range(0, 1) ? -64'sd2147483648 : 64'sd2147483647;
      default: return gen_x[k] +
                      ((gen_x[k+1] - gen_x[k]) * longint'($urandom_range(0, 99))) / 100;
    endcase
  endfunction

  initial begin
    int n, shape;
    int counts[8] = '{2, 3, 64, 127, 17, 64, 5, 40};
    model_count = 0;
    model_mode = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset config gives too few points, then every entry written
    pend_reqs.push_back(make_query(0));
    pend_reqs.push_back(make_query(-64'sd2147483648));
    for (int i = 0; i < MaxPoints; i++)
      pend_reqs.push_back(make_write(i, i * 64'sd1024 - 64'sd30000,
                                     (i % 2) ? 64'sd2147483647 : -64'sd2147483648));
    wait_idle();
    cfg_write(CfgCount, 1);
    pend_reqs.push_back(make_query(-64'sd30000));
    wait_idle();
    cfg_write(CfgCount, MaxPoints);
    pend_reqs.push_back(make_query(-64'sd30000));
    pend_reqs.push_back(make_query(63 * 64'sd1024 - 64'sd30000));
    pend_reqs.push_back(make_query(-64'sd30001));
    pend_reqs.push_back(make_query(64'sd2147483647));
    pend_reqs.push_back(make_query(-64'sd30000 + 512));
    pend_reqs.push_back(make_query(-64'sd30000 + 700));
    // duplicate end x for a zero-width segment, far points for saturation
    pend_reqs.push_back(make_write(1, -64'sd30000, 5));
    pend_reqs.push_back(make_query(-64'sd30000));
    pend_reqs.push_back(make_write(1, -64'sd2147483648, 64'sd2147483647));
    pend_reqs.push_back(make_write(2, 64'sd2147483647, -64'sd2147483648));
    wait_idle();
    cfg_write(CfgCount, 3);
    cfg_write(CfgMode, 0);
    pend_reqs.push_back(make_query(0));
    pend_reqs.push_back(make_query(-64'sd1));
    pend_reqs.push_back(make_query(64'sd2147483647));
    wait_idle();

    // random phases
    for (int p = 0; p < 12; p++) begin
      n = (p < 8) ? counts[p] : $urandom_range(2, MaxPoints);
      shape = $urandom_range(0, 9) < 7 ? $urandom_range(0, 1) : $urandom_range(2, 3);
      quiet = (p >= 10);
      cfg_write(CfgCount, n);
      cfg_write(CfgMode, (p % 3 == 0) ? 0 : 1);
      if (n > MaxPoints) n = MaxPoints;
      build_table(n, shape);
      for (int q = 0; q < 32; q++) begin
        if ($urandom_range(0, 19) == 0)
          pend_reqs.push_back(make_write($urandom_range(0, MaxPoints - 1),
                                         longint'($signed($urandom)),
                                         longint'($signed($urandom))));
        else
          pend_reqs.push_back(make_query(pick_x(n)));
      end
      wait_idle();
    end

    if (errs == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
